// ===== sv/ust_pkg.sv =====
// Package for the set table: operation codes, defaults and result field layout.
package ust_pkg;

  localparam int UST_CAPACITY   = 64;
  localparam int UST_VALUE_BITS = 32;

  localparam int ELEMENT_BITS = 32;
  localparam int COUNT_BITS   = 7;

  typedef enum logic [1:0] {
    FN_QUERY  = 2'd0,
    FN_INSERT = 2'd1,
    FN_DELETE = 2'd2,
    FN_CLEAR  = 2'd3
  } ust_func_t;

  localparam int RES_MEMBER   = 0;
  localparam int RES_COUNT_LO = 1;
  localparam int RES_EMPTY    = 8;
  localparam int RES_FULL     = 9;
  localparam int RES_DROPPED  = 10;
  localparam int RES_BITS     = 16;

endpackage

// ===== sv/unordered_set_table_unit.sv =====
// Top level: set of distinct values with linear scan and compacting delete.
//
//  channel  dir  tdata                     tuser
//  s_axis   in   [31:0] element            [1:0] func
//  m_axis   out  [0] was_member [7:1] count_after [8] empty_flag
//                [9] full_flag [10] insert_dropped [15:11] zero
//
// Every transaction scans the stored entries for query, insert and clear, where the
// scan reads one stored entry per cycle through the single memory read port.
// A scan that matches at slot k stops early.
// A delete that hits slot k then shifts the entries above slot k down by one,
// with nothing to shift when k is the last slot.
// rst clears the count; the store is never cleared. A stalled m_axis holds
// the next transaction in its final state until the result register frees.
module unordered_set_table_unit
  import ust_pkg::*;
#(
  parameter int CAPACITY   = UST_CAPACITY,
  parameter int VALUE_BITS = UST_VALUE_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [ELEMENT_BITS-1:0] s_axis_tdata,  // [31:0] element
  input  logic [1:0]              s_axis_tuser,  // [1:0] func
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [RES_BITS-1:0]     m_axis_tdata   // member, count[7:1], empty, full, dropped
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_SHIFT, ST_DONE} state_t;

  state_t                state;
  ust_func_t             func;
  logic [VALUE_BITS-1:0] val;
  logic [CW-1:0]         count;
  logic [CW-1:0]         idx;
  logic [AW-1:0]         waddr;
  logic                  pend;
  logic                  member;
  logic                  dropped;

  logic                  out_member;
  logic [COUNT_BITS-1:0] out_count;
  logic                  out_empty;
  logic                  out_full;
  logic                  out_dropped;

  logic [VALUE_BITS-1:0] mem [CAPACITY];
  logic [VALUE_BITS-1:0] rd_data;
  logic [AW-1:0]         rd_addr;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [VALUE_BITS-1:0] mem_wdata;

  logic [63:0]           elem_ext;
  logic                  hit;
  logic                  scan_end;
  logic                  is_full;
  logic                  ins_write;

  assign elem_ext = {{32{s_axis_tdata[ELEMENT_BITS-1]}}, s_axis_tdata};

  assign s_axis_tready = (state == ST_IDLE);

  // shared compare unit
  assign hit      = pend && (rd_data == val);
  assign scan_end = hit || (idx >= count);
  assign is_full  = (count >= CW'(CAPACITY));

  assign ins_write = (state == ST_SCAN) && scan_end && !hit
                     && (func == FN_INSERT) && !is_full;

  assign rd_addr   = idx[AW-1:0];
  assign mem_we    = ins_write || ((state == ST_SHIFT) && pend);
  assign mem_waddr = (state == ST_SHIFT) ? waddr : count[AW-1:0];
  assign mem_wdata = (state == ST_SHIFT) ? rd_data : val;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      idx           <= '0;
      pend          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != ST_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            func    <= ust_func_t'(s_axis_tuser);
            val     <= elem_ext[VALUE_BITS-1:0];
            idx     <= '0;
            pend    <= 1'b0;
            dropped <= 1'b0;
            state   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_end) begin
            member <= hit;
            pend   <= 1'b0;
            state  <= ((func == FN_DELETE) && hit) ? ST_SHIFT : ST_DONE;
            case (func)
              FN_INSERT: begin
                if (ins_write) begin
                  count <= count + CW'(1);
                end
                dropped <= !hit && is_full;
              end
              FN_DELETE: begin
                if (hit) begin
                  waddr <= AW'(idx - CW'(1));
                end
              end
              FN_CLEAR: begin
                count <= '0;
              end
              default: begin
              end
            endcase
          end else begin
            idx  <= idx + CW'(1);
            pend <= 1'b1;
          end
        end
        ST_SHIFT: begin
          if (pend) begin
            waddr <= waddr + AW'(1);
          end
          if (idx < count) begin
            idx  <= idx + CW'(1);
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              count <= count - CW'(1);
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            out_member    <= member;
            out_count     <= COUNT_BITS'(count);
            out_empty     <= (count == '0);
            out_full      <= is_full;
            out_dropped   <= dropped;
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    m_axis_tdata                                  = '0;
    m_axis_tdata[RES_MEMBER]                      = out_member;
    m_axis_tdata[RES_COUNT_LO +: COUNT_BITS]      = out_count;
    m_axis_tdata[RES_EMPTY]                       = out_empty;
    m_axis_tdata[RES_FULL]                        = out_full;
    m_axis_tdata[RES_DROPPED]                     = out_dropped;
  end

endmodule

// ===== sv/ust_checker.sv =====
// Port-level checker for the set table, bound to the top level.
module ust_checker
  import ust_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [RES_BITS-1:0] m_axis_tdata
);

  logic [COUNT_BITS-1:0] res_count;

  assign res_count = m_axis_tdata[RES_COUNT_LO +: COUNT_BITS];

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[RES_EMPTY] == (res_count == '0))
    else $error("empty flag disagrees with count");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[RES_DROPPED]
      |-> m_axis_tdata[RES_FULL] && !m_axis_tdata[RES_MEMBER])
    else $error("dropped insert without full set or with a member");

  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second transaction taken while busy");

endmodule

bind unordered_set_table_unit ust_checker u_ust_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/unordered_set_table_unit_tb.sv =====
// Testbench for unordered_set_table_unit: directed table plus random request episodes.
module unordered_set_table_unit_tb;
  import ust_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY    = UST_CAPACITY;
  localparam int TOTAL_ITEMS = 1150;
  localparam int POOL_SIZE   = 40;
  localparam int IDLE_PCT    = 8;
  localparam int N_DIRECTED  = 23;

  typedef struct packed {
    logic                  was_member;
    logic [COUNT_BITS-1:0] count_after;
    logic                  empty_flag;
    logic                  full_flag;
    logic                  insert_dropped;
  } set_result_t;

  typedef struct packed {
    ust_func_t   op;
    logic [31:0] element;
    logic        typed;
    set_result_t result;
  } directed_row_t;

  localparam set_result_t NONE = '0;

  localparam directed_row_t DIRECTED [N_DIRECTED] = '{
    '{FN_QUERY,  32'h0000_0000, 1'b1, '{1'b0, 7'd0, 1'b1, 1'b0, 1'b0}},
    '{FN_DELETE, 32'h0000_0005, 1'b1, '{1'b0, 7'd0, 1'b1, 1'b0, 1'b0}},
    '{FN_CLEAR,  32'hFFFF_FFFF, 1'b1, '{1'b0, 7'd0, 1'b1, 1'b0, 1'b0}},
    '{FN_INSERT, 32'h8000_0000, 1'b1, '{1'b0, 7'd1, 1'b0, 1'b0, 1'b0}},
    '{FN_INSERT, 32'h7FFF_FFFF, 1'b1, '{1'b0, 7'd2, 1'b0, 1'b0, 1'b0}},
    '{FN_INSERT, 32'hFFFF_FFFF, 1'b1, '{1'b0, 7'd3, 1'b0, 1'b0, 1'b0}},
    '{FN_INSERT, 32'h0000_0000, 1'b1, '{1'b0, 7'd4, 1'b0, 1'b0, 1'b0}},
    '{FN_INSERT, 32'h8000_0000, 1'b1, '{1'b1, 7'd4, 1'b0, 1'b0, 1'b0}},
    '{FN_QUERY,  32'h7FFF_FFFE, 1'b0, NONE},
    '{FN_INSERT, 32'h0000_0001, 1'b0, NONE},
    '{FN_DELETE, 32'h7FFF_FFFF, 1'b0, NONE},
    '{FN_QUERY,  32'h0000_0000, 1'b0, NONE},
    '{FN_DELETE, 32'h7FFF_FFFF, 1'b0, NONE},
    '{FN_DELETE, 32'h8000_0000, 1'b0, NONE},
    '{FN_DELETE, 32'h0000_0001, 1'b0, NONE},
    '{FN_QUERY,  32'hFFFF_FFFF, 1'b0, NONE},
    '{FN_INSERT, 32'h7FFF_FFFF, 1'b0, NONE},
    '{FN_CLEAR,  32'h0000_0000, 1'b0, NONE},
    '{FN_QUERY,  32'h0000_0000, 1'b0, NONE},
    '{FN_INSERT, 32'h5555_5555, 1'b0, NONE},
    '{FN_INSERT, 32'hAAAA_AAAA, 1'b0, NONE},
    '{FN_QUERY,  32'h5555_5554, 1'b0, NONE},
    '{FN_CLEAR,  32'h1234_5678, 1'b0, NONE}
  };

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [ELEMENT_BITS-1:0] s_axis_tdata = '0;  // [31:0] element
  logic [1:0]              s_axis_tuser = '0;  // [1:0] func
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [RES_BITS-1:0]     m_axis_tdata;       // member, count[7:1], empty, full, dropped

  unordered_set_table_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // predicted set contents
  logic [31:0] held_vals [CAPACITY];
  int          held_count = 0;
  logic [31:0] value_pool [POOL_SIZE];

  set_result_t pending_results [$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          op_counts [4] = '{0, 0, 0, 0};
  int          dropped_count = 0;
  int          full_count = 0;
  bit          quiet_stretch = 1'b0;

  function automatic set_result_t apply_set_request(ust_func_t op, logic [31:0] element);
    set_result_t r;
    int          hit_at;
    hit_at = -1;
    for (int i = 0; i < held_count; i++)
      if (hit_at < 0 && held_vals[i] == element) hit_at = i;
    r = '0;
    r.was_member = hit_at >= 0;
    case (op)
      FN_INSERT: begin
        if (hit_at < 0) begin
          if (held_count >= CAPACITY) begin
            r.insert_dropped = 1'b1;
          end else begin
            held_vals[held_count] = element;
            held_count++;
          end
        end
      end
      FN_DELETE: begin
        if (hit_at >= 0) begin
          for (int i = hit_at; i + 1 < held_count; i++) held_vals[i] = held_vals[i + 1];
          held_count--;
        end
      end
      FN_CLEAR: held_count = 0;
      default: ;
    endcase
    r.count_after = COUNT_BITS'(held_count);
    r.empty_flag  = held_count == 0;
    r.full_flag   = held_count >= CAPACITY;
    return r;
  endfunction

  function automatic logic [31:0] pick_element();
    int sel;
    sel = $urandom_range(0, 99);
    if (held_count > 0 && sel < 45) return held_vals[$urandom_range(0, held_count - 1)];
    if (held_count > 0 && sel < 55)
      return held_vals[$urandom_range(0, held_count - 1)] ^ (32'd1 << $urandom_range(0, 31));
    if (sel < 85) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom();
  endfunction

  function automatic ust_func_t pick_op(int ins_pct, int del_pct, int qry_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < ins_pct) return FN_INSERT;
    if (r < ins_pct + del_pct) return FN_DELETE;
    if (r < ins_pct + del_pct + qry_pct) return FN_QUERY;
    return FN_CLEAR;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_request(ust_func_t op, logic [31:0] element, logic typed,
                              set_result_t typed_result);
    set_result_t r;
    while (!quiet_stretch && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= element;
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    r = apply_set_request(op, element);
    pending_results.push_back(typed ? typed_result : r);
    op_counts[int'(op)]++;
    if (r.insert_dropped) dropped_count++;
    if (r.full_flag) full_count++;
    items_sent++;
    quiet_stretch = items_sent >= 450 && items_sent < 650;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    m_axis_tready <= quiet_stretch || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    set_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected, tdata=%h", m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("was_member", want.was_member, m_axis_tdata[RES_MEMBER]);
        check_field("count_after", want.count_after,
                    m_axis_tdata[RES_COUNT_LO +: COUNT_BITS]);
        check_field("empty_flag", want.empty_flag, m_axis_tdata[RES_EMPTY]);
        check_field("full_flag", want.full_flag, m_axis_tdata[RES_FULL]);
        check_field("insert_dropped", want.insert_dropped, m_axis_tdata[RES_DROPPED]);
        check_field("reserved_bits", 0, m_axis_tdata[RES_BITS-1:RES_DROPPED+1]);
      end
    end
  end

  initial begin
    int mode;
    for (int i = 0; i < POOL_SIZE; i++) value_pool[i] = $urandom();
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'hFFFF_FFFF;
    value_pool[3] = 32'h0000_0000;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++)
      send_request(DIRECTED[i].op, DIRECTED[i].element, DIRECTED[i].typed,
                   DIRECTED[i].result);
    drain_results();

    while (items_sent < TOTAL_ITEMS) begin
      mode = $urandom_range(0, 9);
      if (mode < 2) begin
        // grow to full, then poke at the full set
        while (held_count < CAPACITY) begin
          if ($urandom_range(0, 9) == 0) send_request(FN_QUERY, pick_element(), 1'b0, NONE);
          else send_request(FN_INSERT, $urandom(), 1'b0, NONE);
        end
        repeat (3) send_request(FN_INSERT, $urandom(), 1'b0, NONE);
        send_request(FN_INSERT, held_vals[$urandom_range(0, CAPACITY - 1)], 1'b0, NONE);
        send_request(FN_QUERY, held_vals[CAPACITY - 1], 1'b0, NONE);
        send_request(FN_DELETE, held_vals[0], 1'b0, NONE);
        send_request(FN_INSERT, $urandom(), 1'b0, NONE);
        send_request(FN_DELETE, held_vals[held_count - 1], 1'b0, NONE);
        send_request(FN_DELETE, held_vals[$urandom_range(1, held_count - 2)], 1'b0, NONE);
        if ($urandom_range(0, 1) == 1) send_request(FN_CLEAR, pick_element(), 1'b0, NONE);
        for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom();
      end else if (mode < 4) begin
        repeat (40) send_request(pick_op(20, 60, 20), pick_element(), 1'b0, NONE);
      end else if (mode < 9) begin
        repeat (60) send_request(pick_op(45, 25, 28), pick_element(), 1'b0, NONE);
      end else begin
        repeat (20) send_request(ust_func_t'($urandom_range(0, 3)), $urandom(), 1'b0, NONE);
      end
      if ($urandom_range(0, 3) == 0) drain_results();
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Ran %0d requests (query %0d, insert %0d, delete %0d, clear %0d), %0d results.",
             items_sent, op_counts[FN_QUERY], op_counts[FN_INSERT], op_counts[FN_DELETE],
             op_counts[FN_CLEAR], results_seen);
    $display("Set reached full on %0d results; %0d inserts were dropped.",
             full_count, dropped_count);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== unordered_set_table_unit.f =====
sv/ust_pkg.sv
sv/unordered_set_table_unit.sv
sv/ust_checker.sv
tb/unordered_set_table_unit_tb.sv
